FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is asserted.
`define VHPG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Implication checked in the cycle after the antecedent, also active during reset.
`define VHPG_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

FILE: rtl/vhpg_pkg.sv
package vhpg_pkg;

    localparam int COUNT_BITS_DEFAULT = 8;
    localparam int WIDE_BITS = 17;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ADMISSION_LEVEL = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_FRAMES    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_FRAMES      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WARMUP_FRAMES   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TAIL_FRAMES     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WARN_FRAMES     = 3'd5;

    localparam logic [1:0] FUNC_VOICE   = 2'd0;
    localparam logic [1:0] FUNC_ARMED   = 2'd1;
    localparam logic [1:0] FUNC_DISCONT = 2'd2;

    localparam logic [1:0] PEND_NONE        = 2'd0;
    localparam logic [1:0] PEND_INTERRUPTED = 2'd1;

    typedef struct packed {
        logic [1:0]         func;
        logic               raw_speech;
        logic signed [11:0] mic_level;
        logic [1:0]         playback_end;
        logic               render_active;
        logic               playback_gain_on;
        logic               reference_present;
    } in_word_t;

    typedef struct packed {
        logic vad_now;
        logic speech_started;
        logic speech_ended;
        logic near_talk;
        logic detector_clear;
        logic reference_warning;
    } out_word_t;

    typedef struct packed {
        logic signed [11:0] admission_level;
        logic [7:0]         start_frames;
        logic [7:0]         end_frames;
        logic [7:0]         warmup_frames;
        logic [7:0]         tail_frames;
        logic [7:0]         warn_frames;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        admission_level: -12'sd400,
        start_frames:    8'd6,
        end_frames:      8'd35,
        warmup_frames:   8'd30,
        tail_frames:     8'd15,
        warn_frames:     8'd50
    };

endpackage

FILE: rtl/vad_hangover_playback_gate_top.sv
// Channel   Ports                         Direction   Word
// input     s_valid, s_ready, s_data      in          one event (in_word_t)
// result    m_valid, m_ready, m_data      out         one voice frame result
// config    cfg_wr_en, cfg_index, cfg_wr_data   in    register write, no wait
//
// One word is accepted per cycle unless the result register is held; a voice
// frame result passes the input and result registers before m_valid shows it.
// The input register and the result register both advance when the result
// register is empty or being taken, so one word per cycle is sustained.
// Playback-armed and discontinuity words update the gate and give no result.
// Reset is synchronous on aresetn low and loads the register defaults.
module vad_hangover_playback_gate_top #(
    parameter int COUNT_BITS = vhpg_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  vhpg_pkg::in_word_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output vhpg_pkg::out_word_t                   m_data,
    input  logic                                  cfg_wr_en,
    input  logic [vhpg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [vhpg_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);

    vhpg_pkg::cfg_t      cfg_reg;
    vhpg_pkg::in_word_t  in_data_reg;
    vhpg_pkg::out_word_t out_data_reg;
    vhpg_pkg::out_word_t core_result;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                core_result_valid;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = core_result_valid;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && core_result_valid) begin
            out_data_reg <= core_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= vhpg_pkg::CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                vhpg_pkg::REG_ADMISSION_LEVEL: cfg_reg.admission_level <= cfg_wr_data;
                vhpg_pkg::REG_START_FRAMES:    cfg_reg.start_frames    <= cfg_wr_data[7:0];
                vhpg_pkg::REG_END_FRAMES:      cfg_reg.end_frames      <= cfg_wr_data[7:0];
                vhpg_pkg::REG_WARMUP_FRAMES:   cfg_reg.warmup_frames   <= cfg_wr_data[7:0];
                vhpg_pkg::REG_TAIL_FRAMES:     cfg_reg.tail_frames     <= cfg_wr_data[7:0];
                vhpg_pkg::REG_WARN_FRAMES:     cfg_reg.warn_frames     <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    vhpg_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (advance),
        .item         (in_data_reg),
        .cfg          (cfg_reg),
        .result       (core_result),
        .result_valid (core_result_valid)
    );

endmodule

FILE: rtl/vhpg_core.sv
module vhpg_core #(
    parameter int COUNT_BITS = vhpg_pkg::COUNT_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  vhpg_pkg::in_word_t item,
    input  vhpg_pkg::cfg_t     cfg,
    output vhpg_pkg::out_word_t result,
    output logic               result_valid
);

    localparam int WB = vhpg_pkg::WIDE_BITS;
    localparam logic [WB-1:0] CNT_MAX = WB'((1 << COUNT_BITS) - 1);

    logic [COUNT_BITS-1:0] speech_run_reg, speech_run_next;
    logic [COUNT_BITS-1:0] silence_run_reg, silence_run_next;
    logic [COUNT_BITS-1:0] suppress_left_reg, suppress_left_next;
    logic [COUNT_BITS-1:0] ref_wait_reg, ref_wait_next;
    logic talking_reg, talking_next;
    logic playing_reg, playing_next;
    logic awaiting_reg, awaiting_next;
    logic silent_pass_reg, silent_pass_next;

    function automatic logic [COUNT_BITS-1:0] clamp_cnt(input logic [7:0] v);
        logic [WB-1:0] w;
        w = WB'(v);
        return (w > CNT_MAX) ? CNT_MAX[COUNT_BITS-1:0] : w[COUNT_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] clamp_min1(input logic [7:0] v);
        return (v == 8'd0) ? COUNT_BITS'(1) : clamp_cnt(v);
    endfunction

    always_comb begin
        logic [COUNT_BITS-1:0] slim;
        logic [COUNT_BITS-1:0] elim;
        logic [COUNT_BITS:0]   run_inc;
        logic [COUNT_BITS-1:0] wait_inc;
        logic                  vad;
        logic                  suppress;

        speech_run_next    = speech_run_reg;
        silence_run_next   = silence_run_reg;
        suppress_left_next = suppress_left_reg;
        ref_wait_next      = ref_wait_reg;
        talking_next       = talking_reg;
        playing_next       = playing_reg;
        awaiting_next      = awaiting_reg;
        silent_pass_next   = silent_pass_reg;
        result             = '0;
        result_valid       = 1'b0;
        slim               = clamp_min1(cfg.start_frames);
        elim               = clamp_min1(cfg.end_frames);
        run_inc            = '0;
        wait_inc           = ref_wait_reg + 1'b1;
        vad                = 1'b0;
        suppress           = 1'b0;

        unique case (item.func)
            vhpg_pkg::FUNC_ARMED: begin
                playing_next       = 1'b1;
                awaiting_next      = 1'b1;
                silent_pass_next   = 1'b0;
                suppress_left_next = '0;
                ref_wait_next      = '0;
            end
            vhpg_pkg::FUNC_DISCONT: begin
                if (playing_reg) begin
                    awaiting_next      = 1'b1;
                    suppress_left_next = '0;
                end
            end
            vhpg_pkg::FUNC_VOICE: begin
                result_valid = 1'b1;
                vad = item.raw_speech
                    && (talking_reg || item.mic_level >= cfg.admission_level);
                if (vad) begin
                    run_inc = {1'b0, speech_run_reg} + 1'b1;
                    speech_run_next = (run_inc > {1'b0, slim})
                        ? slim : run_inc[COUNT_BITS-1:0];
                    silence_run_next = '0;
                end else begin
                    run_inc = {1'b0, silence_run_reg} + 1'b1;
                    silence_run_next = (run_inc > {1'b0, elim})
                        ? elim : run_inc[COUNT_BITS-1:0];
                    speech_run_next = '0;
                end
                if (!talking_reg && speech_run_next >= slim) begin
                    talking_next = 1'b1;
                    result.speech_started = 1'b1;
                end else if (talking_reg && silence_run_next >= elim) begin
                    talking_next = 1'b0;
                    result.speech_ended = 1'b1;
                end

                if (item.playback_end != vhpg_pkg::PEND_NONE) begin
                    playing_next     = 1'b0;
                    awaiting_next    = 1'b0;
                    silent_pass_next = 1'b0;
                    if (item.playback_end == vhpg_pkg::PEND_INTERRUPTED) begin
                        suppress_left_next = '0;
                    end else begin
                        suppress_left_next = clamp_cnt(cfg.tail_frames);
                        suppress = 1'b1;
                    end
                end else if (silent_pass_reg && item.playback_gain_on) begin
                    silent_pass_next = 1'b0;
                    awaiting_next    = 1'b1;
                    ref_wait_next    = '0;
                    suppress         = 1'b1;
                end else if (awaiting_reg) begin
                    suppress = 1'b1;
                    if (!item.render_active) begin
                        ref_wait_next = '0;
                    end else if (!item.playback_gain_on) begin
                        awaiting_next    = 1'b0;
                        silent_pass_next = 1'b1;
                        ref_wait_next    = '0;
                        suppress         = 1'b0;
                    end else if (item.reference_present) begin
                        awaiting_next      = 1'b0;
                        suppress_left_next = clamp_cnt(cfg.warmup_frames);
                        ref_wait_next      = '0;
                    end else if (ref_wait_reg != {COUNT_BITS{1'b1}}) begin
                        ref_wait_next = wait_inc;
                        result.reference_warning =
                            (WB'(wait_inc) == WB'(cfg.warn_frames));
                    end
                end

                if (suppress_left_next != '0) begin
                    suppress = 1'b1;
                    suppress_left_next = suppress_left_next - 1'b1;
                    if (suppress_left_next == '0) begin
                        result.detector_clear = 1'b1;
                        speech_run_next  = '0;
                        silence_run_next = '0;
                        talking_next     = 1'b0;
                    end
                end

                result.vad_now   = vad;
                result.near_talk = vad && !suppress;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speech_run_reg    <= '0;
            silence_run_reg   <= '0;
            suppress_left_reg <= '0;
            ref_wait_reg      <= '0;
            talking_reg       <= 1'b0;
            playing_reg       <= 1'b0;
            awaiting_reg      <= 1'b0;
            silent_pass_reg   <= 1'b0;
        end else if (step_en) begin
            speech_run_reg    <= speech_run_next;
            silence_run_reg   <= silence_run_next;
            suppress_left_reg <= suppress_left_next;
            ref_wait_reg      <= ref_wait_next;
            talking_reg       <= talking_next;
            playing_reg       <= playing_next;
            awaiting_reg      <= awaiting_next;
            silent_pass_reg   <= silent_pass_next;
        end
    end

endmodule

FILE: rtl/vhpg_checker.sv
`include "assert_macros.svh"

module vhpg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input vhpg_pkg::out_word_t m_data
);

    `VHPG_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)
    `VHPG_ASSERT_NEXT(a_valid_holds, aclk, aresetn && m_valid && !m_ready, !aresetn || m_valid)
    `VHPG_ASSERT_SAME(a_near_needs_vad, aclk, aresetn, m_valid && m_data.near_talk, m_data.vad_now)
    `VHPG_ASSERT_SAME(a_warn_suppressed, aclk, aresetn, m_valid && m_data.reference_warning, !m_data.near_talk)
    `VHPG_ASSERT_SAME(a_one_edge, aclk, aresetn, m_valid && m_data.speech_started, !m_data.speech_ended)

endmodule

bind vad_hangover_playback_gate_top vhpg_checker u_vhpg_checker (.*);
